FILE: sv/tssf_pkg.sv
// shared types, constants and the segment table for the temperature frame generator
// no dependencies; imported by every module of the block
package tssf_pkg;

  // input and result payloads
  typedef struct packed {
    logic [31:0] now_ms;
    logic [11:0] temperature;
  } in_t;

  typedef struct packed {
    logic [7:0] bus_byte;
    logic       is_address;
    logic       last_byte;
  } out_t;

  // configuration register file contents
  typedef struct packed {
    logic [15:0] update_interval_ms;
    logic [6:0]  device_address;
    logic [7:0]  control_byte;
  } cfg_t;

  // frame load request from the update gate to the serializer
  typedef struct packed {
    logic        load;
    logic [11:0] temperature;
  } frame_load_t;

  // register indexes on the configuration port
  localparam logic [1:0] REG_INTERVAL = 2'd0;
  localparam logic [1:0] REG_ADDRESS  = 2'd1;
  localparam logic [1:0] REG_CONTROL  = 2'd2;

  // register reset values
  localparam logic [15:0] INTERVAL_RESET = 16'd500;
  localparam logic [6:0]  ADDRESS_RESET  = 7'd56;
  localparam logic [7:0]  CONTROL_RESET  = 8'd23;

  // fixed frame bytes
  localparam logic [7:0] CTRL_REG_INDEX  = 8'd0;
  localparam logic [7:0] DEGREE_SEGMENTS = 8'd99;

  // byte positions within a frame
  localparam logic [2:0] BYTE_ADDR     = 3'd0;
  localparam logic [2:0] BYTE_CTRL_IDX = 3'd1;
  localparam logic [2:0] BYTE_CTRL     = 3'd2;
  localparam logic [2:0] BYTE_DEGREE   = 3'd3;
  localparam logic [2:0] BYTE_ONES     = 3'd4;
  localparam logic [2:0] BYTE_TENS     = 3'd5;
  localparam logic [2:0] BYTE_HUNDREDS = 3'd6;

  // digit unit step codes
  localparam logic [1:0] STEP_ONES     = 2'd0;
  localparam logic [1:0] STEP_TENS     = 2'd1;
  localparam logic [1:0] STEP_HUNDREDS = 2'd2;
  localparam logic [1:0] STEP_DONE     = 2'd3;

  // reciprocal of ten in 16 fractional bits, exact for values below 16384
  localparam logic [12:0] RECIP10 = 13'd6554;

  // seven-segment codes for decimal digits
  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    case (digit)
      4'd0: code = 8'd63;
      4'd1: code = 8'd6;
      4'd2: code = 8'd91;
      4'd3: code = 8'd79;
      4'd4: code = 8'd102;
      4'd5: code = 8'd109;
      4'd6: code = 8'd125;
      4'd7: code = 8'd7;
      4'd8: code = 8'd127;
      4'd9: code = 8'd111;
      default: code = 8'd0;
    endcase
    return code;
  endfunction

endpackage

FILE: sv/tssf_cfg.sv
// configuration register file behind the apb-style port
// depends on tssf_pkg for the register indexes, reset values and cfg_t
module tssf_cfg
  import tssf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = paddr[3:2];

  // register writes, unused index ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.update_interval_ms <= INTERVAL_RESET;
      cfg.device_address     <= ADDRESS_RESET;
      cfg.control_byte       <= CONTROL_RESET;
    end else if (wr) begin
      case (idx)
        REG_INTERVAL: cfg.update_interval_ms <= pwdata[15:0];
        REG_ADDRESS:  cfg.device_address     <= pwdata[6:0];
        REG_CONTROL:  cfg.control_byte       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_INTERVAL: prdata = {16'd0, cfg.update_interval_ms};
      REG_ADDRESS:  prdata = {25'd0, cfg.device_address};
      REG_CONTROL:  prdata = {24'd0, cfg.control_byte};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

FILE: sv/tssf_gate.sv
// input register and update decision: interval check, change check, state update
// depends on tssf_pkg for in_t, cfg_t and frame_load_t
module tssf_gate
  import tssf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  input  cfg_t        cfg,
  input  logic        ser_ready,
  output frame_load_t frame
);

  logic        held;
  in_t         item;
  logic [31:0] last_update_time;
  logic [11:0] last_shown_temp;
  logic [31:0] elapsed;
  logic        update;
  logic        emit;
  logic        consume;
  logic        in_xfer;

  // decision on the held item
  assign elapsed  = item.now_ms - last_update_time;
  assign update   = elapsed > {16'd0, cfg.update_interval_ms};
  assign emit     = update && (item.temperature != last_shown_temp);
  assign consume  = held && (!emit || ser_ready);
  assign in_stall = held && !consume;
  assign in_xfer  = in_valid && !in_stall;

  assign frame.load        = consume && emit;
  assign frame.temperature = item.temperature;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_xfer) begin
      held <= 1'b1;
    end else if (consume) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item <= in_data;
    end
  end

  // display state, updated when the held item leaves after the interval
  always_ff @(posedge clk) begin
    if (rst) begin
      last_update_time <= 32'd0;
      last_shown_temp  <= 12'd0;
    end else if (consume && update) begin
      last_update_time <= item.now_ms;
      if (emit) begin
        last_shown_temp <= item.temperature;
      end
    end
  end

endmodule

FILE: sv/tssf_ser.sv
// frame serializer with a digit unit that splits the temperature one decimal a cycle
// depends on tssf_pkg for out_t, cfg_t, frame_load_t, byte positions and seg_code
module tssf_ser
  import tssf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  frame_load_t frame,
  output logic        ser_ready,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data
);

  logic        busy;
  logic [2:0]  idx;
  logic        out_xfer;
  logic        at_last;
  logic [1:0]  step;
  logic [11:0] quo;
  logic [24:0] prod;
  logic [11:0] q10;
  logic [11:0] rem_full;
  logic [3:0]  rem;
  logic [3:0]  dig_ones;
  logic [3:0]  dig_tens;
  logic [3:0]  dig_hund;

  assign out_valid = busy;
  assign out_xfer  = busy && !out_stall;
  assign at_last   = idx == BYTE_HUNDREDS;
  assign ser_ready = !busy || (at_last && out_xfer);

  // byte counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= BYTE_ADDR;
    end else if (frame.load) begin
      busy <= 1'b1;
      idx  <= BYTE_ADDR;
    end else if (out_xfer) begin
      if (at_last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  // divide by ten through the reciprocal, remainder by subtracting ten times the quotient
  assign prod     = 25'(quo) * 25'(RECIP10);
  assign q10      = {3'd0, prod[24:16]};
  assign rem_full = quo - 12'(q10 * 12'd10);
  assign rem      = rem_full[3:0];

  // digit unit, three steps right after a load, ahead of the digit bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_DONE;
    end else if (frame.load) begin
      step <= STEP_ONES;
    end else if (step != STEP_DONE) begin
      step <= step + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.load) begin
      quo <= frame.temperature;
    end else if (step != STEP_DONE) begin
      quo <= q10;
    end
  end

  always_ff @(posedge clk) begin
    if (!frame.load) begin
      case (step)
        STEP_ONES:     dig_ones <= rem;
        STEP_TENS:     dig_tens <= rem;
        STEP_HUNDREDS: dig_hund <= rem;
        default: ;
      endcase
    end
  end

  // byte select
  always_comb begin
    out_data.is_address = 1'b0;
    out_data.last_byte  = 1'b0;
    case (idx)
      BYTE_ADDR: begin
        out_data.bus_byte   = {1'b0, cfg.device_address};
        out_data.is_address = 1'b1;
      end
      BYTE_CTRL_IDX: out_data.bus_byte = CTRL_REG_INDEX;
      BYTE_CTRL:     out_data.bus_byte = cfg.control_byte;
      BYTE_DEGREE:   out_data.bus_byte = DEGREE_SEGMENTS;
      BYTE_ONES:     out_data.bus_byte = seg_code(dig_ones);
      BYTE_TENS:     out_data.bus_byte = seg_code(dig_tens);
      BYTE_HUNDREDS: begin
        out_data.bus_byte  = seg_code(dig_hund);
        out_data.last_byte = 1'b1;
      end
      default: out_data.bus_byte = 8'd0;
    endcase
  end

`ifndef SYNTHESIS
  // a new frame only loads into an empty serializer or on the final transfer
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    frame.load |-> (!busy || (at_last && out_xfer)))
    else $error("frame loaded over a frame in progress");

  // digits are settled before any digit byte is shown
  a_digits_ready: assert property (@(posedge clk) disable iff (rst)
    (busy && (idx == BYTE_ONES || idx == BYTE_TENS || idx == BYTE_HUNDREDS))
      |-> (step == STEP_DONE))
    else $error("digit byte shown before the digit unit finished");

  // the final transfer with no new load leaves the serializer empty
  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    (out_xfer && at_last && !frame.load) |=> !busy)
    else $error("serializer still busy after the final byte");

  // the byte position never passes the last byte
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (idx <= BYTE_HUNDREDS))
    else $error("byte position out of range");
`endif

endmodule

FILE: sv/temp_seven_segment_frame_gen_core.sv
// top level of the temperature frame generator for a seven-segment display controller
// depends on tssf_pkg, tssf_cfg, tssf_gate and tssf_ser
//
// Each input item (millisecond time, whole-degree temperature) is held in the input
// register, where the interval check and change check are made. An item that
// starts no frame leaves without waiting, so such items can be taken every cycle.
// An item that starts a frame loads the serializer, which shows the first byte in
// the next cycle and then gives seven bytes, one per output transfer; the serializer
// gives one byte per cycle while the output does not stall, and that sets the frame
// rate. A frame-starting item waits in the input register while the previous frame
// is still going out, and loads on the cycle of its final transfer. The three digits
// are found by a digit unit that takes one decimal per cycle, starting in the cycle
// after the load and finishing ahead of the digit bytes.
module temp_seven_segment_frame_gen_core
  import tssf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data
);

  cfg_t        cfg;
  frame_load_t frame;
  logic        ser_ready;

  // configuration registers
  tssf_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register and update decision
  tssf_gate u_gate (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg       (cfg),
    .ser_ready (ser_ready),
    .frame     (frame)
  );

  // frame serializer
  tssf_ser u_ser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .frame     (frame),
    .ser_ready (ser_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
